>>> src/dtff_pkg.sv
package dtff_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;

  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic [31:0]        vertex_a_w;
    logic [31:0]        vertex_b_w;
    logic [31:0]        vertex_c_w;
    logic [31:0]        fill_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         write_x;
    logic [7:0]         write_y;
    logic [31:0]        write_color;
    logic signed [31:0] write_depth;
    logic               written;
    logic               degenerate;
  } out_item_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                    outside;
    logic                    w_zero;
    logic [CoordW-1:0]       px;
    logic [CoordW-1:0]       py;
    logic [31:0]             color;
    logic signed [DiffW-1:0] acx;
    logic signed [DiffW-1:0] acy;
    logic signed [DiffW-1:0] abx;
    logic signed [DiffW-1:0] aby;
    logic signed [DiffW-1:0] apx;
    logic signed [DiffW-1:0] apy;
    logic signed [DiffW-1:0] pcx;
    logic signed [DiffW-1:0] pcy;
    logic signed [DiffW-1:0] pbx;
    logic signed [DiffW-1:0] pby;
    logic [31:0]             wa;
    logic [31:0]             wb;
    logic [31:0]             wc;
  } work_t;

endpackage

>>> src/depth_tested_flat_fragment_top.sv
// channel | direction | handshake               | payload
// input   | in        | in_valid_i / in_stall_o   | in_data_i (dtff_pkg::in_item_t)
// output  | out       | out_valid_o / out_stall_i | out_data_o (dtff_pkg::out_item_t)
// config  | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// a non-degenerate pixel inside the screen needs six products on one shared
// multiplier, five 50-step divisions on one radix-2 divider, three weight products
// and a read-modify-write of the depth memory; an off-screen pixel skips all of these
// after reset the depth memory is filled with 1.0, one entry a cycle, over all
// MAX_COLUMNS*MAX_ROWS entries before the first transaction leaves the queue
// a two-entry queue keeps accepting until full while the back end is busy or the output stalls
module depth_tested_flat_fragment_top #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dtff_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dtff_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dtff_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtff_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [dtff_pkg::CfgDataW-1:0] screen_w_q, screen_h_q;
  dtff_pkg::work_t               work, head;
  logic                          full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= 9'd256;
      screen_h_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtff_pkg::CfgScreenWidth:  screen_w_q <= cfg_data_i;
        dtff_pkg::CfgScreenHeight: screen_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;

  dtff_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .in_i       (in_data_i),
    .screen_w_i (screen_w_q),
    .screen_h_i (screen_h_q),
    .work_o     (work)
  );

  dtff_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (work),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  dtff_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/dtff_front.sv
module dtff_front #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256
) (
  input  dtff_pkg::in_item_t                in_i,
  input  logic [dtff_pkg::CfgDataW-1:0]     screen_w_i,
  input  logic [dtff_pkg::CfgDataW-1:0]     screen_h_i,
  output dtff_pkg::work_t                   work_o
);

  function automatic logic signed [dtff_pkg::DiffW-1:0] sub(
    input logic signed [15:0] a, input logic signed [15:0] b);
    sub = dtff_pkg::DiffW'(a) - dtff_pkg::DiffW'(b);
  endfunction

  logic x_ok, y_ok;

  always_comb begin
    x_ok = !in_i.pixel_x[15] && (in_i.pixel_x < {7'd0, screen_w_i})
        && (in_i.pixel_x < 16'(MAX_COLUMNS));
    y_ok = !in_i.pixel_y[15] && (in_i.pixel_y < {7'd0, screen_h_i})
        && (in_i.pixel_y < 16'(MAX_ROWS));

    work_o.outside = !(x_ok && y_ok);
    work_o.w_zero  = (in_i.vertex_a_w == '0) || (in_i.vertex_b_w == '0)
        || (in_i.vertex_c_w == '0);
    work_o.px      = in_i.pixel_x[dtff_pkg::CoordW-1:0];
    work_o.py      = in_i.pixel_y[dtff_pkg::CoordW-1:0];
    work_o.color   = in_i.fill_color;
    work_o.acx     = sub(in_i.vertex_c_x, in_i.vertex_a_x);
    work_o.acy     = sub(in_i.vertex_c_y, in_i.vertex_a_y);
    work_o.abx     = sub(in_i.vertex_b_x, in_i.vertex_a_x);
    work_o.aby     = sub(in_i.vertex_b_y, in_i.vertex_a_y);
    work_o.apx     = sub(in_i.pixel_x, in_i.vertex_a_x);
    work_o.apy     = sub(in_i.pixel_y, in_i.vertex_a_y);
    work_o.pcx     = sub(in_i.vertex_c_x, in_i.pixel_x);
    work_o.pcy     = sub(in_i.vertex_c_y, in_i.pixel_y);
    work_o.pbx     = sub(in_i.vertex_b_x, in_i.pixel_x);
    work_o.pby     = sub(in_i.vertex_b_y, in_i.pixel_y);
    work_o.wa      = in_i.vertex_a_w;
    work_o.wb      = in_i.vertex_b_w;
    work_o.wc      = in_i.vertex_c_w;
  end

endmodule

>>> src/dtff_queue.sv
module dtff_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dtff_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output dtff_pkg::work_t head_o
);

  dtff_pkg::work_t slot_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

endmodule

>>> src/dtff_div.sv
module dtff_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [49:0] quot_o
);

  logic [34:0] rem_q, rem_d;
  logic [49:0] quo_q;
  logic [33:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [34:0] shifted;
  logic        fits;

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    shifted = {rem_q[33:0], quo_q[49]};
    fits    = (shifted >= {1'b0, dvs_q});
    rem_d   = fits ? (shifted - {1'b0, dvs_q}) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd49) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[48:0], fits};
    end
  end

endmodule

>>> src/dtff_back.sv
module dtff_back #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  dtff_pkg::work_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dtff_pkg::out_item_t out_data_o
);

  localparam int unsigned Entries = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW      = $clog2(Entries);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_CHK, S_DGO, S_DWT, S_GAM, S_WMUL, S_SAT, S_RD, S_CMP, S_OUT
  } state_e;

  function automatic logic signed [31:0] sat32_34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF)       sat32_34 = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) sat32_34 = 32'sh8000_0000;
    else                            sat32_34 = v[31:0];
  endfunction

  state_e                  state_q;
  logic [2:0]              idx_q;
  logic [AW-1:0]           clr_q;
  dtff_pkg::work_t         it_q;
  logic signed [34:0]      area_q, nb_q, na_q;
  logic signed [31:0]      beta_q, alpha_q, gamma_q, depth_q, rd_q;
  logic [31:0]             ra_q, rb_q, rc_q;
  logic signed [48:0]      sum_q;
  logic signed [65:0]      prod_q;
  dtff_pkg::out_item_t     res_q, out_q;
  logic                    out_valid_q;

  logic signed [32:0]      ma, mb;
  logic signed [65:0]      prod;
  logic signed [34:0]      term35;
  logic signed [48:0]      term49;
  logic                    div_start, div_done;
  logic [49:0]             div_dividend, div_quot;
  logic [33:0]             div_divisor;
  logic signed [34:0]      num;
  logic [34:0]             num_mag, area_mag;
  logic                    q_neg;
  logic signed [31:0]      q_weight;
  logic [31:0]             q_recip;
  logic signed [31:0]      sum_sat;
  logic [AW-1:0]           addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [31:0]      mem_wdata;
  logic signed [31:0]      mem [Entries];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;

  assign addr = AW'(32'(it_q.py) * MAX_COLUMNS + 32'(it_q.px));

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_MUL) begin
      case (idx_q)
        3'd0: begin ma = 33'(it_q.acx); mb = 33'(it_q.aby); end
        3'd1: begin ma = 33'(it_q.acy); mb = 33'(it_q.abx); end
        3'd2: begin ma = 33'(it_q.acx); mb = 33'(it_q.apy); end
        3'd3: begin ma = 33'(it_q.acy); mb = 33'(it_q.apx); end
        3'd4: begin ma = 33'(it_q.pcx); mb = 33'(it_q.pby); end
        3'd5: begin ma = 33'(it_q.pcy); mb = 33'(it_q.pbx); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else begin
      case (idx_q)
        3'd0: begin ma = 33'(alpha_q); mb = $signed({1'b0, ra_q}); end
        3'd1: begin ma = 33'(beta_q);  mb = $signed({1'b0, rb_q}); end
        3'd2: begin ma = 33'(gamma_q); mb = $signed({1'b0, rc_q}); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
    prod   = ma * mb;
    term35 = prod_q[34:0];
    term49 = 49'(prod_q >>> 16);
  end

  // divider operands and result shaping
  always_comb begin
    num      = (idx_q == 3'd0) ? nb_q : na_q;
    num_mag  = num[34] ? 35'(-num) : 35'(num);
    area_mag = area_q[34] ? 35'(-area_q) : 35'(area_q);
    q_neg    = num[34] ^ area_q[34];
    case (idx_q)
      3'd0, 3'd1: begin
        div_dividend = {num_mag[33:0], 16'd0};
        div_divisor  = area_mag[33:0];
      end
      3'd2: begin div_dividend = 50'h1_0000_0000; div_divisor = {2'd0, it_q.wa}; end
      3'd3: begin div_dividend = 50'h1_0000_0000; div_divisor = {2'd0, it_q.wb}; end
      default: begin div_dividend = 50'h1_0000_0000; div_divisor = {2'd0, it_q.wc}; end
    endcase
    if (!q_neg) q_weight = (div_quot > 50'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_quot[31:0];
    else        q_weight = (div_quot > 50'h8000_0000) ? 32'sh8000_0000 : -div_quot[31:0];
    q_recip   = (div_quot > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
    div_start = (state_q == S_DGO);
    sum_sat   = (sum_q > 49'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
              : (sum_q < -49'sh8000_0000) ? 32'sh8000_0000 : sum_q[31:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = depth_q;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = dtff_pkg::OneQ16;
    end else if (state_q == S_CMP && depth_q < rd_q) begin
      mem_we = 1'b1;
    end
  end

  dtff_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state_q == S_RD) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the output slot is refilled from S_OUT in the same cycle it drains
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(Entries - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty_i) begin
            it_q  <= head_i;
            idx_q <= '0;
            res_q <= '0;
            if (head_i.outside) state_q <= S_OUT;
            else                state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= prod;
          idx_q  <= idx_q + 3'd1;
          case (idx_q)
            3'd1: area_q <= term35;
            3'd2: area_q <= area_q - term35;
            3'd3: nb_q   <= term35;
            3'd4: nb_q   <= nb_q - term35;
            3'd5: na_q   <= term35;
            3'd6: na_q   <= na_q - term35;
            default: ;
          endcase
          if (idx_q == 3'd6) state_q <= S_CHK;
        end
        S_CHK: begin
          res_q.write_x     <= it_q.px[7:0];
          res_q.write_y     <= it_q.py[7:0];
          res_q.write_color <= it_q.color;
          idx_q             <= '0;
          if (area_q == '0 || it_q.w_zero) begin
            res_q.degenerate <= 1'b1;
            state_q          <= S_OUT;
          end else begin
            state_q <= S_DGO;
          end
        end
        S_DGO: state_q <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            case (idx_q)
              3'd0:    beta_q  <= q_weight;
              3'd1:    alpha_q <= q_weight;
              3'd2:    ra_q    <= q_recip;
              3'd3:    rb_q    <= q_recip;
              default: rc_q    <= q_recip;
            endcase
            if (idx_q == 3'd4) state_q <= S_GAM;
            else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= S_DGO;
            end
          end
        end
        S_GAM: begin
          gamma_q <= sat32_34(34'(dtff_pkg::OneQ16) - 34'(beta_q) - 34'(alpha_q));
          idx_q   <= '0;
          state_q <= S_WMUL;
        end
        S_WMUL: begin
          prod_q <= prod;
          idx_q  <= idx_q + 3'd1;
          // floor by 2^16 is the arithmetic shift
          if (idx_q == 3'd1)      sum_q <= term49;
          else if (idx_q != 3'd0) sum_q <= sum_q + term49;
          if (idx_q == 3'd3) state_q <= S_SAT;
        end
        S_SAT: begin
          depth_q <= sat32_34(34'(dtff_pkg::OneQ16) - 34'(sum_sat));
          state_q <= S_RD;
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          res_q.write_depth <= depth_q;
          res_q.written     <= (depth_q < rd_q);
          state_q           <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
